// ----- rtl/rbd_pkg.sv -----
// Shared types, sizes and helpers for the 2x2 RGB box downscaler.
`default_nettype none
package rbd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int CH_W      = 8;                 // one colour channel
  localparam int SUM_W     = CH_W + 1;          // sum of two samples
  localparam int PAIR_W    = 3 * SUM_W;         // red, green, blue pair sums
  localparam int PIX_W     = 3 * CH_W;
  localparam int DIM_W     = 13;                // size register width
  localparam int CNT_W     = $clog2(MAX_WIDTH); // column and row counters
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W    = $clog2(LINE_DEPTH);
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

  // position of the word being accepted
  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic             frame_end;
  } pos_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    begin
      if (v < DIM_W'(2)) res = DIM_W'(2);
      else if (v > maxv) res = maxv;
      else res = v;
      return res;
    end
  endfunction

  // index of the last column or row that still takes part in an output
  function automatic logic [CNT_W-1:0] last_idx(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] tmp;
    begin
      tmp = {v[DIM_W-1:1], 1'b0} - DIM_W'(1);
      return tmp[CNT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rbd_line_ram.sv -----
// Line buffer of horizontal pair sums, one write port and one registered read port.
`default_nettype none
module rbd_line_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [rbd_pkg::ADDR_W-1:0] waddr,
  input  wire logic [rbd_pkg::PAIR_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [rbd_pkg::ADDR_W-1:0] raddr,
  output logic      [rbd_pkg::PAIR_W-1:0] rdata
);
  import rbd_pkg::*;

  logic [PAIR_W-1:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rbd_pos.sv -----
// Frame size registers and column/row position counters.
`default_nettype none
module rbd_pos (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rbd_pkg::DIM_W-1:0]     cfg_wdata,
  input  wire logic                         step,
  output rbd_pkg::pos_t                     pos
);
  import rbd_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  logic [CNT_W-1:0] last_col_r, last_row_r;
  logic [CNT_W-1:0] col_r, row_r;
  logic [CNT_W-1:0] col_nxt, row_nxt;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic [DIM_W-1:0] width_nxt, height_nxt;

  assign width_nxt  = clamp_dim(cfg_wdata, DIM_W'(MAX_WIDTH));
  assign height_nxt = clamp_dim(cfg_wdata, DIM_W'(MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      last_col_r <= last_idx(WIDTH_RESET);
      last_row_r <= last_idx(HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          width_r    <= width_nxt;
          last_col_r <= last_idx(width_nxt);
        end
        REG_FRAME_HEIGHT: begin
          height_r   <= height_nxt;
          last_row_r <= last_idx(height_nxt);
        end
        default: ;
      endcase
    end
  end

  assign col_inc = {1'b0, col_r} + DIM_W'(1);
  assign row_inc = {1'b0, row_r} + DIM_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (col_inc >= width_r) begin
        col_nxt = '0;
        row_nxt = (row_inc >= height_r) ? '0 : row_inc[CNT_W-1:0];
      end else begin
        col_nxt = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign pos.col       = col_r;
  assign pos.row       = row_r;
  assign pos.frame_end = (col_r == last_col_r) && (row_r == last_row_r);

endmodule
`default_nettype wire

// ----- rtl/rgb_box_downscale_2x2.sv -----
// Top level: 2x2 box-filter RGB downscaler with a pair-sum line buffer.
// Throughput: one input word per cycle while the output is not stalled; one output word per 2x2 block.
// Path: the word closing a block passes through the line buffer read and stage 1 registers,
//   then the output register, which drives out_tvalid.
// Reset: counters and valid flags clear synchronously, size registers load 1920 by 1080
//   and in_tready is held low; the line buffer is not cleared, every entry is written
//   on an even row before it is read.
`default_nettype none
module rgb_box_downscale_2x2 (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rbd_pkg::DIM_W-1:0]     cfg_wdata,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [rbd_pkg::PIX_W-1:0]     in_tdata,  // red_in, green_in, blue_in
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [rbd_pkg::PIX_W-1:0]     out_tdata, // red_out, green_out, blue_out
  output logic                              out_tlast  // frame_end
);
  import rbd_pkg::*;

  pos_t              pos;
  logic              accept;
  logic              close_pair;
  logic [CH_W-1:0]   red, green, blue;
  logic [PAIR_W-1:0] pair_r, pair_nxt, pair_sum;
  logic [PAIR_W-1:0] above;
  logic              ram_we, ram_re;
  logic              out_move;

  logic              s1_valid_r;
  logic [PAIR_W-1:0] s1_sum_r;
  logic              s1_last_r;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_data_r, out_data_nxt;
  logic              out_last_r;

  assign red   = in_tdata[CH_W-1:0];
  assign green = in_tdata[2*CH_W-1:CH_W];
  assign blue  = in_tdata[3*CH_W-1:2*CH_W];

  assign out_move  = !out_valid_r || out_tready;
  assign in_tready = rst_n && (!s1_valid_r || out_move);
  assign accept    = in_tvalid && in_tready;

  rbd_pos u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (accept),
    .pos       (pos)
  );

  // horizontal pair sums, one 9-bit field per channel
  assign pair_sum = {pair_r[3*SUM_W-1:2*SUM_W] + {1'b0, blue},
                     pair_r[2*SUM_W-1:SUM_W]   + {1'b0, green},
                     pair_r[SUM_W-1:0]         + {1'b0, red}};

  assign close_pair = pos.col[0];
  assign pair_nxt   = close_pair ? pair_sum : {1'b0, blue, 1'b0, green, 1'b0, red};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r <= '0;
    end else if (accept) begin
      pair_r <= pair_nxt;
    end
  end

  assign ram_we = accept && close_pair && !pos.row[0];
  assign ram_re = accept && close_pair &&  pos.row[0];

  rbd_line_ram u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos.col[CNT_W-1:1]),
    .wdata (pair_sum),
    .re    (ram_re),
    .raddr (pos.col[CNT_W-1:1]),
    .rdata (above)
  );

  // stage 1 waits alongside the line buffer read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_sum_r  <= pair_sum;
      s1_last_r <= pos.frame_end;
    end
  end

  // four-sample sums are 10 bits; keep bits 9:2
  always_comb begin
    logic [SUM_W:0] r4, g4, b4;
    r4 = {1'b0, above[SUM_W-1:0]}         + {1'b0, s1_sum_r[SUM_W-1:0]};
    g4 = {1'b0, above[2*SUM_W-1:SUM_W]}   + {1'b0, s1_sum_r[2*SUM_W-1:SUM_W]};
    b4 = {1'b0, above[3*SUM_W-1:2*SUM_W]} + {1'b0, s1_sum_r[3*SUM_W-1:2*SUM_W]};
    out_data_nxt = {b4[SUM_W:2], g4[SUM_W:2], r4[SUM_W:2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && s1_valid_r) begin
      out_data_r <= out_data_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
